// ----- src/sbs_pkg.sv -----
// Shared types, instruction codes and helpers for the stack bytecode step core.
`default_nettype none

package sbs_pkg;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_STR    = 2'd1,
		KIND_NATIVE = 2'd2,
		KIND_SYS    = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		SUB_ENTER    = 6'd0,
		SUB_LEAVE    = 6'd1,
		SUB_RET      = 6'd2,
		SUB_LOAD     = 6'd3,
		SUB_STORE    = 6'd4,
		SUB_POP_RR   = 6'd5,
		SUB_PUSH_RR  = 6'd6,
		SUB_PUT_RR   = 6'd7,
		SUB_GET_RR   = 6'd8,
		SUB_PUSH_IMM = 6'd9,
		SUB_CALL     = 6'd10
	} sub_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] instr;
		logic [31:0] data_value;
		logic [15:0] func_offset;
		logic [15:0] start_offset;
	} item_t;

	typedef struct packed {
		logic native_call;
		logic fault;
	} exec_flags_t;

	// frame base plus signed 8-bit offset
	function automatic logic signed [9:0] slot_pos(input logic [7:0] fb, input logic [7:0] n);
		return $signed({2'b00, fb}) + $signed({{2{n[7]}}, n});
	endfunction

endpackage

`default_nettype wire

// ----- src/sbs_stack_ram.sv -----
// Word stack storage: one write port, one read port, registered read data.
`default_nettype none

module sbs_stack_ram #(
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/sbs_exec.sv -----
// Instruction decode, stack read address and next-state computation.
`default_nettype none

module sbs_exec import sbs_pkg::*; #(
	parameter int STACK_DEPTH = 256,
	parameter int CODE_WORDS = 32768,
	localparam int AW = $clog2(STACK_DEPTH),
	localparam int SP_W = $clog2(STACK_DEPTH + 1),
	localparam int IP_W = $clog2(CODE_WORDS)
) (
	input  wire item_t            item,
	input  wire logic [SP_W-1:0]  top,
	input  wire logic [7:0]       fb,
	input  wire logic [IP_W-1:0]  ip,
	input  wire logic [31:0]      rr,
	input  wire phase_t           phase,
	input  wire logic [31:0]      rdata,
	output logic      [AW-1:0]    raddr,
	output logic                  wr_en,
	output logic      [AW-1:0]    wr_addr,
	output logic      [31:0]      wr_data,
	output logic      [SP_W-1:0]  nxt_top,
	output logic      [7:0]       nxt_fb,
	output logic      [IP_W-1:0]  nxt_ip,
	output logic      [31:0]      nxt_rr,
	output phase_t                nxt_phase,
	output exec_flags_t           flags
);

	localparam int EW = ((SP_W > 9) ? SP_W : 9) + 1;
	localparam int XW = (AW > 9) ? AW : 9;

	kind_t              kind;
	sub_t               sub;
	logic [7:0]         n;
	logic [EW-1:0]      t_e;
	logic [EW-1:0]      n1;
	logic [EW-1:0]      t_sub_n1;
	logic [EW-1:0]      t_add_n1;
	logic [EW-1:0]      t1_e;
	logic [SP_W-1:0]    t_inc;
	logic [SP_W-1:0]    t_dec;
	logic               full;
	logic               empty;
	logic               under;
	logic               tp1_ok;
	logic               a_ok;
	logic signed [9:0]  slot;
	logic               slot_ok;
	logic [XW-1:0]      slot_w;
	logic [AW-1:0]      slot_ix;
	logic [IP_W-1:0]    ip_nx;
	logic [31:0]        call_ret;
	logic [16:0]        soff_half;
	logic [16:0]        foff_half;

	assign kind      = kind_t'(item.instr[15:14]);
	assign sub       = sub_t'(item.instr[13:8]);
	assign n         = item.instr[7:0];
	assign t_e       = EW'(top);
	assign n1        = EW'(n) + EW'(1);
	assign t_sub_n1  = t_e - n1;
	assign t_add_n1  = t_e + n1;
	assign t1_e      = t_e + EW'(1);
	assign t_inc     = top + SP_W'(1);
	assign t_dec     = top - SP_W'(1);
	assign full      = (top == SP_W'(STACK_DEPTH));
	assign empty     = (top == '0);
	assign under     = (t_e < n1);
	assign tp1_ok    = (t1_e <= EW'(255)) && (t1_e < EW'(STACK_DEPTH));
	assign a_ok      = (rdata[31:8] == '0) && (rdata < 32'(STACK_DEPTH));
	assign slot      = slot_pos(fb, n);
	assign slot_ok   = !slot[9] && ({23'd0, slot[8:0]} < 32'(STACK_DEPTH));
	assign slot_w    = XW'(slot[8:0]);
	assign slot_ix   = slot_w[AW-1:0];
	assign ip_nx     = (ip == IP_W'(CODE_WORDS - 1)) ? '0 : ip + IP_W'(1);
	assign call_ret  = 32'(ip) + 32'd1;
	assign soff_half = {2'b00, item.start_offset[15:1]};
	assign foff_half = {2'b00, item.func_offset[15:1]};

	always_comb begin
		raddr = '0;
		if (kind == KIND_SYS) begin
			case (sub)
				SUB_LEAVE:  raddr = t_sub_n1[AW-1:0];
				SUB_RET,
				SUB_STORE,
				SUB_POP_RR: raddr = t_dec[AW-1:0];
				SUB_LOAD,
				SUB_GET_RR: raddr = slot_ix;
				default:    raddr = '0;
			endcase
		end
	end

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = top[AW-1:0];
		wr_data   = '0;
		nxt_top   = top;
		nxt_fb    = fb;
		nxt_ip    = ip;
		nxt_rr    = rr;
		nxt_phase = phase;
		flags     = '0;
		if (!item.req_type) begin
			nxt_ip    = soff_half[IP_W-1:0];
			nxt_top   = SP_W'(1);
			nxt_fb    = '0;
			wr_en     = 1'b1;
			wr_addr   = '0;
			wr_data   = '0;
			nxt_phase = PH_RUN;
		end else if (phase != PH_RUN) begin
			flags.fault = 1'b1;
		end else begin
			case (kind)
				KIND_DATA, KIND_STR: begin
					if (full) begin
						flags.fault = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_data = (kind == KIND_DATA) ? item.data_value
							: {18'd0, item.instr[13:0]};
						nxt_top = t_inc;
						nxt_ip  = ip_nx;
					end
				end
				KIND_NATIVE: begin
					flags.native_call = 1'b1;
					nxt_ip = ip_nx;
				end
				KIND_SYS: begin
					case (sub)
						SUB_ENTER: begin
							if (t_add_n1 > EW'(STACK_DEPTH) || !tp1_ok) begin
								flags.fault = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_data = {24'd0, fb};
								nxt_fb  = t1_e[7:0];
								nxt_top = SP_W'(t_add_n1);
								nxt_ip  = ip_nx;
							end
						end
						SUB_LEAVE: begin
							if (under || !a_ok) begin
								flags.fault = 1'b1;
							end else begin
								nxt_top = SP_W'(t_sub_n1);
								nxt_fb  = rdata[7:0];
								nxt_ip  = ip_nx;
							end
						end
						SUB_RET: begin
							if (under) begin
								flags.fault = 1'b1;
							end else begin
								nxt_top = SP_W'(t_sub_n1);
								if (rdata == '0) begin
									nxt_phase = PH_DONE;
									nxt_ip    = '0;
								end else begin
									nxt_ip = rdata[IP_W-1:0];
								end
							end
						end
						SUB_LOAD: begin
							if (!slot_ok || full) begin
								flags.fault = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_data = rdata;
								nxt_top = t_inc;
								nxt_ip  = ip_nx;
							end
						end
						SUB_STORE: begin
							if (!slot_ok || empty) begin
								flags.fault = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_addr = slot_ix;
								wr_data = rdata;
								nxt_top = t_dec;
								nxt_ip  = ip_nx;
							end
						end
						SUB_POP_RR: begin
							if (empty) begin
								flags.fault = 1'b1;
							end else begin
								nxt_rr  = rdata;
								nxt_top = t_dec;
								nxt_ip  = ip_nx;
							end
						end
						SUB_PUSH_RR, SUB_PUSH_IMM: begin
							if (full) begin
								flags.fault = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_data = (sub == SUB_PUSH_RR) ? rr : {24'd0, n};
								nxt_top = t_inc;
								nxt_ip  = ip_nx;
							end
						end
						SUB_PUT_RR: begin
							if (!slot_ok) begin
								flags.fault = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_addr = slot_ix;
								wr_data = rr;
								nxt_ip  = ip_nx;
							end
						end
						SUB_GET_RR: begin
							if (!slot_ok) begin
								flags.fault = 1'b1;
							end else begin
								nxt_rr = rdata;
								nxt_ip = ip_nx;
							end
						end
						SUB_CALL: begin
							if (full) begin
								flags.fault = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_data = call_ret;
								nxt_top = t_inc;
								nxt_ip  = foff_half[IP_W-1:0];
							end
						end
						default: begin
							flags.fault = 1'b1;
						end
					endcase
				end
				default: begin
					flags.fault = 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/stack_bytecode_step_core.sv -----
// Top level of the stack bytecode step core: handshake, state registers, result register.
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   req_type instr data_value func_offset start_offset
// out      output     out_valid / out_ready next_ip stack_ptr frame_ptr return_value
//                                           native_call native_index finished fault
//
// One instruction at a time: the stack memory read is issued on the accept edge and
// the read-modify-write completes once the result register is free, so the synchronous
// stack memory port sets the rate. A new transfer is taken while the previous result
// waits in the result register. A stalled output holds the item in place and re-reads
// the same entry. Reset clears the pointers, the return register and the run phase; the
// stack memory is not cleared. Code address wrap assumes CODE_WORDS is a power of two.
`default_nettype none

module stack_bytecode_step_core import sbs_pkg::*; #(
	parameter int STACK_DEPTH = 256,
	parameter int CODE_WORDS = 32768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [15:0] instr,
	input  wire logic [31:0] data_value,
	input  wire logic [15:0] func_offset,
	input  wire logic [15:0] start_offset,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [14:0] next_ip,
	output logic      [8:0]  stack_ptr,
	output logic      [7:0]  frame_ptr,
	output logic      [31:0] return_value,
	output logic             native_call,
	output logic      [13:0] native_index,
	output logic             finished,
	output logic             fault
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int IP_W = $clog2(CODE_WORDS);

	logic            valid_s1;
	item_t           item_s1;
	item_t           in_item;
	item_t           ex_item;
	logic [SP_W-1:0] top_q;
	logic [7:0]      fb_q;
	logic [IP_W-1:0] ip_q;
	logic [31:0]     rr_q;
	phase_t          phase_q;
	logic            out_valid_q;
	logic [14:0]     next_ip_q;
	logic [8:0]      stack_ptr_q;
	logic [7:0]      frame_ptr_q;
	logic [31:0]     return_value_q;
	logic            native_call_q;
	logic [13:0]     native_index_q;
	logic            finished_q;
	logic            fault_q;
	logic            in_fire;
	logic            s1_fire;
	logic            done_nx;
	logic [31:0]     rdata;
	logic [AW-1:0]   raddr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [31:0]     wr_data;
	logic [SP_W-1:0] nxt_top;
	logic [7:0]      nxt_fb;
	logic [IP_W-1:0] nxt_ip;
	logic [31:0]     nxt_rr;
	phase_t          nxt_phase;
	exec_flags_t     flags;

	assign in_item  = '{req_type, instr, data_value, func_offset, start_offset};
	assign in_ready = !valid_s1;
	assign in_fire  = in_valid && in_ready;
	assign s1_fire  = valid_s1 && (!out_valid_q || out_ready);
	assign ex_item  = valid_s1 ? item_s1 : in_item;

	sbs_exec #(
		.STACK_DEPTH(STACK_DEPTH),
		.CODE_WORDS(CODE_WORDS)
	) u_exec (
		.item(ex_item),
		.top(top_q),
		.fb(fb_q),
		.ip(ip_q),
		.rr(rr_q),
		.phase(phase_q),
		.rdata(rdata),
		.raddr(raddr),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.nxt_top(nxt_top),
		.nxt_fb(nxt_fb),
		.nxt_ip(nxt_ip),
		.nxt_rr(nxt_rr),
		.nxt_phase(nxt_phase),
		.flags(flags)
	);

	sbs_stack_ram #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk(clk),
		.we(s1_fire && wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		done_nx = (nxt_phase == PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			fb_q    <= '0;
			ip_q    <= '0;
			rr_q    <= '0;
			phase_q <= PH_IDLE;
		end else if (s1_fire) begin
			top_q   <= nxt_top;
			fb_q    <= nxt_fb;
			ip_q    <= nxt_ip;
			rr_q    <= nxt_rr;
			phase_q <= nxt_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			next_ip_q      <= 15'(nxt_ip);
			stack_ptr_q    <= 9'(nxt_top);
			frame_ptr_q    <= nxt_fb;
			return_value_q <= nxt_rr;
			native_call_q  <= flags.native_call;
			native_index_q <= flags.native_call ? item_s1.instr[13:0] : '0;
			finished_q     <= done_nx;
			fault_q        <= flags.fault;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_ip      = next_ip_q;
	assign stack_ptr    = stack_ptr_q;
	assign frame_ptr    = frame_ptr_q;
	assign return_value = return_value_q;
	assign native_call  = native_call_q;
	assign native_index = native_index_q;
	assign finished     = finished_q;
	assign fault        = fault_q;

`ifndef SYNTH
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_fault_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && flags.fault |=>
		top_q == $past(top_q) && fb_q == $past(fb_q) && ip_q == $past(ip_q))
		else $error("faulting instruction changed machine state");

	a_finish_ip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && finished_q && !$past(phase_q == PH_DONE) |-> next_ip_q == '0)
		else $error("run ended without clearing the instruction pointer");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_stack_bytecode_step_core.sv -----
// Testbench for stack_bytecode_step_core: directed and random instruction streams checked against a predictor.
module tb_stack_bytecode_step_core;
	import sbs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 500;

	// machine state mirrored by the predictor; wr marks stack words written since reset
	typedef struct packed {
		logic [255:0][31:0] mem;
		logic [255:0]       wr;
		logic [8:0]         top;
		logic [7:0]         fb;
		logic [14:0]        ip;
		logic [31:0]        rr;
		phase_t             phase;
	} vm_t;

	typedef struct packed {
		logic [14:0] next_ip;
		logic [8:0]  stack_ptr;
		logic [7:0]  frame_ptr;
		logic [31:0] return_value;
		logic        native_call;
		logic [13:0] native_index;
		logic        finished;
		logic        fault;
	} step_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [15:0] instr = '0;
	logic [31:0] data_value = '0;
	logic [15:0] func_offset = '0;
	logic [15:0] start_offset = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [14:0] next_ip;
	logic [8:0]  stack_ptr;
	logic [7:0]  frame_ptr;
	logic [31:0] return_value;
	logic        native_call;
	logic [13:0] native_index;
	logic        finished;
	logic        fault;

	stack_bytecode_step_core dut (.*);

	always #4 clk = ~clk;

	item_t        pending_items[$];
	step_result_t expected_steps[$];
	vm_t          plan_vm;
	vm_t          live_vm;
	int           total_items = 0;
	int           accepted_cnt = 0;
	int           checked_cnt = 0;
	int           err_cnt = 0;
	int           fault_cnt = 0;
	int           native_cnt = 0;
	int           done_cnt = 0;
	int           cycle_cnt = 0;
	logic         in_fire = 1'b0;
	int           burst_left = 1;
	int           gap_left = 0;
	int           hold_left = 0;
	bit           hold_used = 1'b0;
	int           rx_mode = 0;
	int           rx_mode_left = 0;
	item_t        drive_item;
	item_t        fed_item;
	step_result_t want;
	step_result_t fed_result;
	bit           fed_bad;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got_v);
		if (got_v !== exp_v)
			report_mismatch($sformatf("%s expected 0x%0h got 0x%0h (result %0d)",
				name, exp_v, got_v, checked_cnt));
	endtask

	// one step of the machine; state is left untouched on a fault
	function automatic void exec_step(inout vm_t m, input item_t it, output step_result_t r,
			output bit bad_read);
		vm_t         s;
		logic [7:0]  n;
		sub_t        sub;
		logic [14:0] nxt;
		logic [31:0] a;
		logic        flt;
		logic        nat;
		logic [13:0] nidx;
		int          top;
		int          idx;
		int          ai;
		bit          slot_ok;
		s = m;
		flt = 1'b0;
		nat = 1'b0;
		nidx = '0;
		bad_read = 1'b0;
		n = it.instr[7:0];
		sub = sub_t'(it.instr[13:8]);
		top = int'(s.top);
		nxt = s.ip + 15'd1;
		idx = int'(s.fb) + int'($signed(n));
		slot_ok = idx >= 0 && idx < 256;
		if (!it.req_type) begin
			s.ip = it.start_offset[15:1];
			s.fb = '0;
			s.mem[0] = '0;
			s.wr[0] = 1'b1;
			s.top = 9'd1;
			s.phase = PH_RUN;
		end else if (s.phase != PH_RUN) begin
			flt = 1'b1;
		end else begin
			case (it.instr[15:14])
				KIND_DATA, KIND_STR: begin
					if (top >= 256) flt = 1'b1;
					else begin
						s.mem[top] = (it.instr[15:14] == KIND_DATA) ? it.data_value
							: {18'b0, it.instr[13:0]};
						s.wr[top] = 1'b1;
						s.top = 9'(top + 1);
						s.ip = nxt;
					end
				end
				KIND_NATIVE: begin
					nat = 1'b1;
					nidx = it.instr[13:0];
					s.ip = nxt;
				end
				default: begin
					case (sub)
						SUB_ENTER: begin
							if (top + 1 + int'(n) > 256 || top + 1 > 255) flt = 1'b1;
							else begin
								s.mem[top] = {24'b0, s.fb};
								s.wr[top] = 1'b1;
								s.fb = 8'(top + 1);
								s.top = 9'(top + 1 + int'(n));
							end
						end
						SUB_LEAVE: begin
							if (top < int'(n) + 1) flt = 1'b1;
							else begin
								ai = top - int'(n) - 1;
								bad_read = !s.wr[ai];
								a = s.mem[ai];
								if (a > 32'd255) flt = 1'b1;
								else begin
									s.top = 9'(ai);
									s.fb = a[7:0];
								end
							end
						end
						SUB_RET: begin
							if (top < int'(n) + 1) flt = 1'b1;
							else begin
								bad_read = !s.wr[top - 1];
								a = s.mem[top - 1];
								s.top = 9'(top - int'(n) - 1);
								if (a == '0) begin
									s.phase = PH_DONE;
									s.ip = '0;
								end else begin
									s.ip = a[14:0];
								end
							end
						end
						SUB_LOAD: begin
							if (!slot_ok || top >= 256) flt = 1'b1;
							else begin
								bad_read = !s.wr[idx];
								s.mem[top] = s.mem[idx];
								s.wr[top] = 1'b1;
								s.top = 9'(top + 1);
							end
						end
						SUB_STORE: begin
							if (!slot_ok || top == 0) flt = 1'b1;
							else begin
								bad_read = !s.wr[top - 1];
								s.mem[idx] = s.mem[top - 1];
								s.wr[idx] = 1'b1;
								s.top = 9'(top - 1);
							end
						end
						SUB_POP_RR: begin
							if (top == 0) flt = 1'b1;
							else begin
								bad_read = !s.wr[top - 1];
								s.rr = s.mem[top - 1];
								s.top = 9'(top - 1);
							end
						end
						SUB_PUSH_RR, SUB_PUSH_IMM: begin
							if (top >= 256) flt = 1'b1;
							else begin
								s.mem[top] = (sub == SUB_PUSH_RR) ? s.rr : {24'b0, n};
								s.wr[top] = 1'b1;
								s.top = 9'(top + 1);
							end
						end
						SUB_PUT_RR: begin
							if (!slot_ok) flt = 1'b1;
							else begin
								s.mem[idx] = s.rr;
								s.wr[idx] = 1'b1;
							end
						end
						SUB_GET_RR: begin
							if (!slot_ok) flt = 1'b1;
							else begin
								bad_read = !s.wr[idx];
								s.rr = s.mem[idx];
							end
						end
						SUB_CALL: begin
							if (top >= 256) flt = 1'b1;
							else begin
								// return address kept unwrapped
								s.mem[top] = {17'b0, s.ip} + 32'd1;
								s.wr[top] = 1'b1;
								s.top = 9'(top + 1);
								s.ip = it.func_offset[15:1];
							end
						end
						default: flt = 1'b1;
					endcase
					if (!flt && sub != SUB_RET && sub != SUB_CALL)
						s.ip = nxt;
				end
			endcase
		end
		if (!flt)
			m = s;
		r.next_ip = m.ip;
		r.stack_ptr = m.top;
		r.frame_ptr = m.fb;
		r.return_value = m.rr;
		r.native_call = nat && !flt;
		r.native_index = flt ? 14'd0 : nidx;
		r.finished = (m.phase == PH_DONE);
		r.fault = flt;
	endfunction

	function automatic logic [15:0] sys_word(input sub_t op, input logic [7:0] n);
		return {KIND_SYS, op, n};
	endfunction

	function automatic item_t exec_item(input logic [15:0] w);
		item_t it;
		it.req_type = 1'b1;
		it.instr = w;
		it.data_value = $urandom;
		it.func_offset = 16'($urandom);
		it.start_offset = 16'($urandom);
		return it;
	endfunction

	function automatic item_t start_item(input logic [15:0] soff);
		item_t it;
		it = exec_item(16'($urandom));
		it.req_type = 1'b0;
		it.start_offset = soff;
		return it;
	endfunction

	// queue an item unless it would read a stack word never written
	function automatic bit try_queue(input item_t it);
		vm_t          trial;
		step_result_t r;
		bit           bad;
		trial = plan_vm;
		exec_step(trial, it, r, bad);
		if (bad)
			return 1'b0;
		plan_vm = trial;
		pending_items.push_back(it);
		total_items++;
		return 1'b1;
	endfunction

	// random instruction shaped by the planned state: frames, locals, calls and returns
	function automatic item_t pick_instr();
		item_t      it;
		int         top;
		int         fb;
		int         lo;
		int         hi;
		int         off;
		int         r;
		logic [7:0] slot_n;
		logic [7:0] n;
		it = exec_item(16'($urandom));
		top = int'(plan_vm.top);
		fb = int'(plan_vm.fb);
		lo = (fb > 128) ? -128 : -fb;
		hi = (top - fb - 1 > 127) ? 127 : top - fb - 1;
		if (hi >= lo && $urandom_range(0, 4) != 0)
			off = lo + int'($urandom_range(0, hi - lo));
		else
			off = $urandom_range(0, 255);
		slot_n = off[7:0];
		r = $urandom_range(0, 99);
		if (r < 12) begin
			it.instr = {KIND_DATA, 14'($urandom)};
			if ($urandom_range(0, 1)) it.data_value = $urandom_range(0, 40);
		end else if (r < 18) begin
			it.instr = {KIND_STR, 14'($urandom)};
		end else if (r < 24) begin
			it.instr = {KIND_NATIVE, 14'($urandom)};
		end else if (r < 34) begin
			n = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
			it.instr = sys_word(SUB_ENTER, n);
		end else if (r < 42) begin
			if (fb > 0 && top >= fb && top - fb <= 255 && $urandom_range(0, 4) != 0)
				n = 8'(top - fb);
			else
				n = 8'($urandom_range(0, 3));
			it.instr = sys_word(SUB_LEAVE, n);
		end else if (r < 48) begin
			n = ($urandom_range(0, 4) != 0) ? 8'd0 : 8'($urandom_range(1, 3));
			it.instr = sys_word(SUB_RET, n);
		end else if (r < 56) begin
			it.instr = sys_word(SUB_LOAD, slot_n);
		end else if (r < 64) begin
			it.instr = sys_word(SUB_STORE, slot_n);
		end else if (r < 68) begin
			it.instr = sys_word(SUB_POP_RR, 8'($urandom));
		end else if (r < 72) begin
			it.instr = sys_word(SUB_PUSH_RR, 8'($urandom));
		end else if (r < 76) begin
			it.instr = sys_word(SUB_PUT_RR, slot_n);
		end else if (r < 80) begin
			it.instr = sys_word(SUB_GET_RR, slot_n);
		end else if (r < 86) begin
			it.instr = sys_word(SUB_PUSH_IMM, 8'($urandom));
		end else if (r < 91) begin
			it.instr = sys_word(SUB_CALL, 8'($urandom));
		end else if (r < 95) begin
			it.instr = {KIND_SYS, 6'($urandom_range(SUB_CALL + 1, 63)), 8'($urandom)};
		end
		return it;
	endfunction

	// driver: new item on the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_items.size() > 0) begin
				drive_item = pending_items.pop_front();
				in_valid <= 1'b1;
				req_type <= drive_item.req_type;
				instr <= drive_item.instr;
				data_value <= drive_item.data_value;
				func_offset <= drive_item.func_offset;
				start_offset <= drive_item.start_offset;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long hold-off of the result side, once, mid-run
	always @(negedge clk) begin
		if (!hold_used && checked_cnt >= 150) begin
			hold_left <= 120;
			hold_used <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin : rx_pace
		bit rdy;
		if (rx_mode_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_mode_left <= $urandom_range(20, 120);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			0: rdy = 1'b1;
			1: rdy = 1'($urandom_range(0, 1));
			default: rdy = ($urandom_range(0, 3) == 0);
		endcase
		out_ready <= arst_n && hold_left == 0 && rdy;
	end

	// monitor: check results in order, predict each accepted transfer
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_steps.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_steps.pop_front();
					check_field("next_ip", 32'(want.next_ip), 32'(next_ip));
					check_field("stack_ptr", 32'(want.stack_ptr), 32'(stack_ptr));
					check_field("frame_ptr", 32'(want.frame_ptr), 32'(frame_ptr));
					check_field("return_value", want.return_value, return_value);
					check_field("native_call", 32'(want.native_call), 32'(native_call));
					check_field("native_index", 32'(want.native_index), 32'(native_index));
					check_field("finished", 32'(want.finished), 32'(finished));
					check_field("fault", 32'(want.fault), 32'(fault));
					checked_cnt++;
					if (want.fault) fault_cnt++;
					if (want.native_call) native_cnt++;
					if (want.finished) done_cnt++;
				end
			end
			if (in_valid && in_ready) begin
				fed_item = {req_type, instr, data_value, func_offset, start_offset};
				exec_step(live_vm, fed_item, fed_result, fed_bad);
				if (fed_bad)
					report_mismatch("accepted transfer reads a stack word never written");
				expected_steps.push_back(fed_result);
				accepted_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
				expected_steps.size());
			$display("stack_bytecode_step_core test failed");
			$finish;
		end
	end

	initial begin
		item_t      it;
		int         directed_cnt;
		int         len;
		int         t;
		bit         placed;
		logic [15:0] soff;
		plan_vm = '0;
		live_vm = '0;

		// directed: idle execute, field extremes, every sub-op, faults, run end
		void'(try_queue(exec_item({KIND_DATA, 14'h0000})));
		void'(try_queue(start_item(16'hFFFF)));
		it = exec_item({KIND_DATA, 14'h3FFF});
		it.data_value = '1;
		void'(try_queue(it));
		void'(try_queue(exec_item({KIND_STR, 14'h3FFF})));
		void'(try_queue(exec_item({KIND_NATIVE, 14'h3FFF})));
		void'(try_queue(exec_item(sys_word(SUB_PUSH_IMM, 8'hFF))));
		void'(try_queue(exec_item(sys_word(SUB_POP_RR, 8'h00))));
		void'(try_queue(exec_item(sys_word(SUB_PUSH_RR, 8'h00))));
		void'(try_queue(exec_item(sys_word(SUB_ENTER, 8'd2))));
		void'(try_queue(exec_item(sys_word(SUB_PUT_RR, 8'h00))));
		void'(try_queue(exec_item(sys_word(SUB_LOAD, 8'h00))));
		void'(try_queue(exec_item(sys_word(SUB_STORE, 8'h01))));
		void'(try_queue(exec_item(sys_word(SUB_GET_RR, 8'hFF))));
		void'(try_queue(exec_item(sys_word(SUB_LOAD, 8'h80))));
		it = exec_item(sys_word(SUB_CALL, 8'h00));
		it.func_offset = 16'hFFFF;
		void'(try_queue(it));
		void'(try_queue(exec_item(sys_word(SUB_RET, 8'd0))));
		void'(try_queue(exec_item(sys_word(SUB_LEAVE, 8'd2))));
		void'(try_queue(exec_item(sys_word(SUB_LEAVE, 8'd9))));
		void'(try_queue(exec_item({KIND_SYS, 6'($urandom_range(SUB_CALL + 1, 63)), 8'h00})));
		void'(try_queue(exec_item(sys_word(SUB_ENTER, 8'hFF))));
		void'(try_queue(exec_item(sys_word(SUB_ENTER, 8'd250))));
		void'(try_queue(exec_item(sys_word(SUB_ENTER, 8'd0))));
		void'(try_queue(exec_item(sys_word(SUB_PUSH_IMM, 8'h00))));
		void'(try_queue(exec_item(sys_word(SUB_PUSH_IMM, 8'h01))));
		void'(try_queue(exec_item(sys_word(SUB_LEAVE, 8'd251))));
		void'(try_queue(exec_item(sys_word(SUB_LEAVE, 8'd1))));
		void'(try_queue(exec_item(sys_word(SUB_RET, 8'd2))));
		void'(try_queue(exec_item(sys_word(SUB_RET, 8'd0))));
		void'(try_queue(exec_item(sys_word(SUB_PUSH_IMM, 8'h00))));
		directed_cnt = total_items;

		// random programs: start, a run of shaped instructions, then a little noise
		while (total_items < directed_cnt + RANDOM_ITEMS) begin
			soff = ($urandom_range(0, 4) == 0) ? (16'hFFF0 | 16'($urandom_range(0, 15)))
				: 16'($urandom);
			void'(try_queue(start_item(soff)));
			len = $urandom_range(4, 48);
			for (int j = 0; j < len && plan_vm.phase == PH_RUN; j++) begin
				placed = 1'b0;
				for (t = 0; t < 16 && !placed; t++)
					placed = try_queue(pick_instr());
				if (!placed)
					void'(try_queue(exec_item(sys_word(SUB_PUSH_IMM, 8'($urandom)))));
			end
			repeat ($urandom_range(0, 2))
				void'(try_queue(pick_instr()));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (accepted_cnt == total_items);
		while (expected_steps.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (expected_steps.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", expected_steps.size()));
		$display("%0d transfers checked (%0d directed), %0d faults, %0d native calls",
			checked_cnt, directed_cnt, fault_cnt, native_cnt);
		$display("%0d results after run end, %0d mismatches", done_cnt, err_cnt);
		if (err_cnt == 0)
			$display("stack_bytecode_step_core test passed");
		else
			$display("stack_bytecode_step_core test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/sbs_pkg.sv
src/sbs_stack_ram.sv
src/sbs_exec.sv
src/stack_bytecode_step_core.sv
dv/tb_stack_bytecode_step_core.sv
